>>> sv/bpbf_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helpers of the bilinear boris pusher
package bpbf_pkg;

	localparam int GRID_NX = 64;
	localparam int GRID_NZ = 64;
	localparam int ADDR_W = 12;
	localparam int STORE_DEPTH = 1 << ADDR_W;
	localparam int GIDX_W = 10;
	localparam int LIN_W = 2 * GIDX_W;
	localparam int Q_W = 32;
	localparam int FRAC_W = 16;
	localparam int VEC_W = 3 * Q_W;
	localparam int D_W = 48;
	localparam int REM_W = 34;
	localparam int FAC_W = 18;
	localparam int DIV_STAGES = FAC_W / 2;
	localparam int CFG_IDX_W = 3;
	localparam int IN_TDATA_W = 272;
	localparam int OUT_TDATA_W = VEC_W;

	typedef enum logic [1:0] {
		FUNC_LOAD_E = 2'd0,
		FUNC_LOAD_B = 2'd1,
		FUNC_PUSH   = 2'd2
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ORIGIN_X   = 3'd0,
		CFG_ORIGIN_Z   = 3'd1,
		CFG_INV_CELL_X = 3'd2,
		CFG_INV_CELL_Z = 3'd3,
		CFG_HALF_EM_DT = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic signed [Q_W-1:0] origin_x;
		logic signed [Q_W-1:0] origin_z;
		logic [Q_W-2:0]        inv_cell_x;
		logic [Q_W-2:0]        inv_cell_z;
		logic signed [Q_W-1:0] half_em_dt;
	} cfg_t;

	// located item: corner addresses, weights and payload
	typedef struct packed {
		logic [1:0]        func;
		logic              oog;
		logic [ADDR_W-1:0] a00;
		logic [ADDR_W-1:0] a01;
		logic [ADDR_W-1:0] a10;
		logic [ADDR_W-1:0] a11;
		logic [FRAC_W-1:0] wx;
		logic [FRAC_W-1:0] wz;
		logic [VEC_W-1:0]  fld;
		logic [VEC_W-1:0]  vel;
	} loc_t;

	// corner vectors read from the field stores
	typedef struct packed {
		logic              oog;
		logic [FRAC_W-1:0] wx;
		logic [FRAC_W-1:0] wz;
		logic [VEC_W-1:0]  vel;
		logic [VEC_W-1:0]  e00;
		logic [VEC_W-1:0]  e01;
		logic [VEC_W-1:0]  e10;
		logic [VEC_W-1:0]  e11;
		logic [VEC_W-1:0]  b00;
		logic [VEC_W-1:0]  b01;
		logic [VEC_W-1:0]  b10;
		logic [VEC_W-1:0]  b11;
	} rd_t;

	// scaled fields at the particle
	typedef struct packed {
		logic             oog;
		logic [VEC_W-1:0] vel;
		logic [VEC_W-1:0] e;
		logic [VEC_W-1:0] b;
	} fld_t;

	function automatic logic signed [Q_W-1:0] comp(input logic [VEC_W-1:0] v,
		input int unsigned c);
		return $signed(v[c*Q_W +: Q_W]);
	endfunction

	function automatic logic signed [Q_W-1:0] sat_q(input logic signed [63:0] x);
		logic signed [Q_W-1:0] r;
		if (x > 64'sh0000_0000_7fff_ffff) r = 32'sh7fff_ffff;
		else if (x < 64'shffff_ffff_8000_0000) r = 32'sh8000_0000;
		else r = x[Q_W-1:0];
		return r;
	endfunction

endpackage

>>> sv/bpbf_locate.sv
`timescale 1ns / 1ps
// grid location: normalized position, cell index, weights and corner addresses
module bpbf_locate (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bpbf_pkg::cfg_t                 cfg,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     in_func,
	input  logic [bpbf_pkg::ADDR_W-1:0]    in_cell_index,
	input  logic [bpbf_pkg::VEC_W-1:0]     in_fld,
	input  logic signed [bpbf_pkg::Q_W-1:0] in_pos_x,
	input  logic signed [bpbf_pkg::Q_W-1:0] in_pos_z,
	input  logic [bpbf_pkg::VEC_W-1:0]     in_vel,
	output logic                           out_valid,
	input  logic                           out_ready,
	output bpbf_pkg::loc_t                 out_loc
);

	typedef struct packed {
		logic [1:0]                  func;
		logic [bpbf_pkg::ADDR_W-1:0] ld_addr;
		logic [bpbf_pkg::VEC_W-1:0]  fld;
		logic [bpbf_pkg::VEC_W-1:0]  vel;
	} lm_t;

	logic [4:1] valid_s;
	logic [4:1] en;

	lm_t lm_s1, lm_s2, lm_s3;
	logic signed [bpbf_pkg::Q_W-1:0] px_s1, pz_s1;
	logic signed [bpbf_pkg::Q_W:0]   dx_s2, dz_s2;
	logic signed [2*bpbf_pkg::Q_W:0] prx_s3, prz_s3;
	bpbf_pkg::loc_t loc_s4;

	logic [49:0] xn, zn;
	logic        oog;
	logic [bpbf_pkg::LIN_W-1:0]  lin;
	logic [bpbf_pkg::ADDR_W-1:0] a00, a10;

	logic known_func;

	assign known_func = (in_func == bpbf_pkg::FUNC_LOAD_E) || (in_func == bpbf_pkg::FUNC_LOAD_B)
		|| (in_func == bpbf_pkg::FUNC_PUSH);

	always_comb begin
		en[4] = !valid_s[4] || out_ready;
		for (int n = 3; n >= 1; n--) en[n] = !valid_s[n] || en[n+1];
	end

	assign in_ready = en[1];
	assign out_valid = valid_s[4];
	assign out_loc = loc_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			// unused function code is taken and dropped
			if (en[1]) valid_s[1] <= in_valid && known_func;
			for (int n = 2; n <= 4; n++) begin
				if (en[n]) valid_s[n] <= valid_s[n-1];
			end
		end
	end

	// floor shift of the scaled offset, plus half a cell
	always_comb begin
		xn = {prx_s3[64], prx_s3[64:16]} + 50'd32768;
		zn = {prz_s3[64], prz_s3[64:16]} + 50'd32768;
		oog = xn[49] || (xn[49:16] > 34'(bpbf_pkg::GRID_NX - 2))
			|| zn[49] || (zn[49:16] > 34'(bpbf_pkg::GRID_NZ - 2));
		lin = bpbf_pkg::LIN_W'(zn[16 +: bpbf_pkg::GIDX_W]) * bpbf_pkg::LIN_W'(bpbf_pkg::GRID_NX)
			+ bpbf_pkg::LIN_W'(xn[16 +: bpbf_pkg::GIDX_W]);
		a00 = (lm_s3.func == bpbf_pkg::FUNC_PUSH) ? lin[bpbf_pkg::ADDR_W-1:0] : lm_s3.ld_addr;
		a10 = a00 + bpbf_pkg::ADDR_W'(bpbf_pkg::GRID_NX);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			lm_s1 <= '{func: in_func, ld_addr: in_cell_index, fld: in_fld, vel: in_vel};
			px_s1 <= in_pos_x;
			pz_s1 <= in_pos_z;
		end
		if (en[2]) begin
			lm_s2 <= lm_s1;
			dx_s2 <= {px_s1[31], px_s1} - {cfg.origin_x[31], cfg.origin_x};
			dz_s2 <= {pz_s1[31], pz_s1} - {cfg.origin_z[31], cfg.origin_z};
		end
		if (en[3]) begin
			lm_s3 <= lm_s2;
			prx_s3 <= dx_s2 * $signed({1'b0, cfg.inv_cell_x});
			prz_s3 <= dz_s2 * $signed({1'b0, cfg.inv_cell_z});
		end
		if (en[4]) begin
			loc_s4.func <= lm_s3.func;
			loc_s4.oog <= oog;
			loc_s4.a00 <= a00;
			loc_s4.a01 <= a00 + bpbf_pkg::ADDR_W'(1);
			loc_s4.a10 <= a10;
			loc_s4.a11 <= a10 + bpbf_pkg::ADDR_W'(1);
			loc_s4.wx <= xn[bpbf_pkg::FRAC_W-1:0];
			loc_s4.wz <= zn[bpbf_pkg::FRAC_W-1:0];
			loc_s4.fld <= lm_s3.fld;
			loc_s4.vel <= lm_s3.vel;
		end
	end

endmodule

>>> sv/bpbf_store.sv
`timescale 1ns / 1ps
// field stores: loads write, pushes read four corners in the same stage
module bpbf_store (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  bpbf_pkg::loc_t in_loc,
	output logic           out_valid,
	input  logic           out_ready,
	output bpbf_pkg::rd_t  out_rd
);

	// two copies of each store: one serves the lower row, one the upper row
	logic [bpbf_pkg::VEC_W-1:0] e_lo_mem [bpbf_pkg::STORE_DEPTH];
	logic [bpbf_pkg::VEC_W-1:0] e_hi_mem [bpbf_pkg::STORE_DEPTH];
	logic [bpbf_pkg::VEC_W-1:0] b_lo_mem [bpbf_pkg::STORE_DEPTH];
	logic [bpbf_pkg::VEC_W-1:0] b_hi_mem [bpbf_pkg::STORE_DEPTH];

	logic          valid_s5;
	logic          en;
	bpbf_pkg::rd_t rd_s5;

	assign en = !valid_s5 || out_ready;
	assign in_ready = en;
	assign out_valid = valid_s5;
	assign out_rd = rd_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			// loads end here
			valid_s5 <= in_valid && (in_loc.func == bpbf_pkg::FUNC_PUSH);
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid && (in_loc.func == bpbf_pkg::FUNC_LOAD_E)) begin
			e_lo_mem[in_loc.a00] <= in_loc.fld;
			e_hi_mem[in_loc.a00] <= in_loc.fld;
		end
		if (en && in_valid && (in_loc.func == bpbf_pkg::FUNC_LOAD_B)) begin
			b_lo_mem[in_loc.a00] <= in_loc.fld;
			b_hi_mem[in_loc.a00] <= in_loc.fld;
		end
		if (en) begin
			rd_s5.e00 <= e_lo_mem[in_loc.a00];
			rd_s5.e01 <= e_lo_mem[in_loc.a01];
			rd_s5.e10 <= e_hi_mem[in_loc.a10];
			rd_s5.e11 <= e_hi_mem[in_loc.a11];
			rd_s5.b00 <= b_lo_mem[in_loc.a00];
			rd_s5.b01 <= b_lo_mem[in_loc.a01];
			rd_s5.b10 <= b_hi_mem[in_loc.a10];
			rd_s5.b11 <= b_hi_mem[in_loc.a11];
			rd_s5.oog <= in_loc.oog;
			rd_s5.wx <= in_loc.wx;
			rd_s5.wz <= in_loc.wz;
			rd_s5.vel <= in_loc.vel;
		end
	end

endmodule

>>> sv/bpbf_interp.sv
`timescale 1ns / 1ps
// bilinear interpolation of six field lanes and scaling by half_em_dt
module bpbf_interp (
	input  logic           clk,
	input  logic           arst_n,
	input  bpbf_pkg::cfg_t cfg,
	input  logic           in_valid,
	output logic           in_ready,
	input  bpbf_pkg::rd_t  in_rd,
	output logic           out_valid,
	input  logic           out_ready,
	output bpbf_pkg::fld_t out_fld
);

	localparam int LANES = 6;

	typedef struct packed {
		logic                        oog;
		logic [bpbf_pkg::FRAC_W-1:0] wx;
		logic [bpbf_pkg::FRAC_W-1:0] wz;
		logic [bpbf_pkg::VEC_W-1:0]  vel;
	} im_t;

	logic [13:6] valid_s;
	logic [13:6] en;

	im_t meta_s [6:13];

	logic signed [bpbf_pkg::Q_W-1:0] c00 [LANES], c01 [LANES], c10 [LANES], c11 [LANES];

	logic signed [bpbf_pkg::Q_W-1:0] a0_s6 [LANES], a1_s6 [LANES];
	logic signed [bpbf_pkg::Q_W:0]   d0_s6 [LANES], d1_s6 [LANES];
	logic signed [bpbf_pkg::Q_W-1:0] a0_s7 [LANES], a1_s7 [LANES];
	logic signed [49:0]              m0_s7 [LANES], m1_s7 [LANES];
	logic signed [bpbf_pkg::Q_W-1:0] r0_s8 [LANES], r1_s8 [LANES];
	logic signed [bpbf_pkg::Q_W-1:0] r0_s9 [LANES];
	logic signed [bpbf_pkg::Q_W:0]   dz_s9 [LANES];
	logic signed [bpbf_pkg::Q_W-1:0] r0_s10 [LANES];
	logic signed [49:0]              mz_s10 [LANES];
	logic signed [bpbf_pkg::Q_W-1:0] f_s11 [LANES];
	logic signed [63:0]              p_s12 [LANES];
	logic signed [bpbf_pkg::Q_W-1:0] s_s13 [LANES];

	always_comb begin
		en[13] = !valid_s[13] || out_ready;
		for (int n = 12; n >= 6; n--) en[n] = !valid_s[n] || en[n+1];
	end

	assign in_ready = en[6];
	assign out_valid = valid_s[13];
	assign out_fld.oog = meta_s[13].oog;
	assign out_fld.vel = meta_s[13].vel;
	assign out_fld.e = {s_s13[2], s_s13[1], s_s13[0]};
	assign out_fld.b = {s_s13[5], s_s13[4], s_s13[3]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			if (en[6]) valid_s[6] <= in_valid;
			for (int n = 7; n <= 13; n++) begin
				if (en[n]) valid_s[n] <= valid_s[n-1];
			end
		end
	end

	// lanes 0 to 2 are electric, 3 to 5 magnetic
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			c00[l] = bpbf_pkg::comp(in_rd.e00, l);
			c01[l] = bpbf_pkg::comp(in_rd.e01, l);
			c10[l] = bpbf_pkg::comp(in_rd.e10, l);
			c11[l] = bpbf_pkg::comp(in_rd.e11, l);
			c00[l+3] = bpbf_pkg::comp(in_rd.b00, l);
			c01[l+3] = bpbf_pkg::comp(in_rd.b01, l);
			c10[l+3] = bpbf_pkg::comp(in_rd.b10, l);
			c11[l+3] = bpbf_pkg::comp(in_rd.b11, l);
		end
	end

	always_ff @(posedge clk) begin
		if (en[6]) meta_s[6] <= '{oog: in_rd.oog, wx: in_rd.wx, wz: in_rd.wz, vel: in_rd.vel};
		for (int n = 7; n <= 13; n++) begin
			if (en[n]) meta_s[n] <= meta_s[n-1];
		end
		for (int l = 0; l < LANES; l++) begin
			// lerp as a + (b - a) * w, exact against the two-product form
			if (en[6]) begin
				a0_s6[l] <= c00[l];
				a1_s6[l] <= c10[l];
				d0_s6[l] <= 33'(c01[l]) - 33'(c00[l]);
				d1_s6[l] <= 33'(c11[l]) - 33'(c10[l]);
			end
			if (en[7]) begin
				a0_s7[l] <= a0_s6[l];
				a1_s7[l] <= a1_s6[l];
				m0_s7[l] <= d0_s6[l] * $signed({1'b0, meta_s[6].wx});
				m1_s7[l] <= d1_s6[l] * $signed({1'b0, meta_s[6].wx});
			end
			if (en[8]) begin
				r0_s8[l] <= a0_s7[l] + m0_s7[l][47:16];
				r1_s8[l] <= a1_s7[l] + m1_s7[l][47:16];
			end
			if (en[9]) begin
				r0_s9[l] <= r0_s8[l];
				dz_s9[l] <= 33'(r1_s8[l]) - 33'(r0_s8[l]);
			end
			if (en[10]) begin
				r0_s10[l] <= r0_s9[l];
				mz_s10[l] <= dz_s9[l] * $signed({1'b0, meta_s[9].wz});
			end
			if (en[11]) f_s11[l] <= r0_s10[l] + mz_s10[l][47:16];
			if (en[12]) p_s12[l] <= f_s11[l] * cfg.half_em_dt;
			if (en[13]) s_s13[l] <= bpbf_pkg::sat_q(p_s12[l] >>> bpbf_pkg::FRAC_W);
		end
	end

endmodule

>>> sv/bpbf_recip.sv
`timescale 1ns / 1ps
// pipelined restoring divider for 2^33 / d, two quotient bits per stage
module bpbf_recip (
	input  logic                           clk,
	input  logic [bpbf_pkg::DIV_STAGES-1:0] en,
	input  logic [bpbf_pkg::D_W-1:0]       d_in,
	output logic [bpbf_pkg::FAC_W-1:0]     fac
);

	logic [bpbf_pkg::REM_W-1:0] rem_s [bpbf_pkg::DIV_STAGES];
	logic [bpbf_pkg::FAC_W-1:0] q_s   [bpbf_pkg::DIV_STAGES];
	logic [bpbf_pkg::D_W-1:0]   d_s   [bpbf_pkg::DIV_STAGES];

	assign fac = q_s[bpbf_pkg::DIV_STAGES-1];

	for (genvar r = 0; r < bpbf_pkg::DIV_STAGES; r++) begin : g_stage
		localparam int HI = bpbf_pkg::FAC_W - 1 - 2 * r;

		logic [bpbf_pkg::REM_W-1:0] rem_in, rem_mid, rem_out;
		logic [bpbf_pkg::FAC_W-1:0] q_in, q_out;
		logic [bpbf_pkg::D_W-1:0]   d_r;
		logic                       fit_hi, fit_lo;

		if (r == 0) begin : g_first
			assign rem_in = bpbf_pkg::REM_W'(1) << (bpbf_pkg::REM_W - 1);
			assign q_in = '0;
			assign d_r = d_in;
		end else begin : g_next
			assign rem_in = rem_s[r-1];
			assign q_in = q_s[r-1];
			assign d_r = d_s[r-1];
		end

		// rem >= d * 2^i compares as floor(rem / 2^i) >= d
		always_comb begin
			fit_hi = bpbf_pkg::D_W'(rem_in >> HI) >= d_r;
			rem_mid = fit_hi ? rem_in - bpbf_pkg::REM_W'(d_r << HI) : rem_in;
			fit_lo = bpbf_pkg::D_W'(rem_mid >> (HI - 1)) >= d_r;
			rem_out = fit_lo ? rem_mid - bpbf_pkg::REM_W'(d_r << (HI - 1)) : rem_mid;
			q_out = q_in;
			q_out[HI] = fit_hi;
			q_out[HI-1] = fit_lo;
		end

		always_ff @(posedge clk) begin
			if (en[r]) begin
				rem_s[r] <= rem_out;
				q_s[r] <= q_out;
				d_s[r] <= d_r;
			end
		end
	end

endmodule

>>> sv/bpbf_kick.sv
`timescale 1ns / 1ps
// boris half-kick, rotation and second half-kick
module bpbf_kick (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  bpbf_pkg::fld_t             in_fld,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [bpbf_pkg::VEC_W-1:0] out_vel,
	output logic                       out_oog
);

	localparam int FIRST = 14;
	localparam int LAST = 26;

	typedef struct packed {
		logic                       oog;
		logic [bpbf_pkg::VEC_W-1:0] vel;
		logic [bpbf_pkg::VEC_W-1:0] vm;
		logic [bpbf_pkg::VEC_W-1:0] e;
		logic [bpbf_pkg::VEC_W-1:0] b;
	} car_t;

	logic [LAST:FIRST] valid_s;
	logic [LAST:FIRST] en;

	car_t car_s [FIRST:LAST];

	logic [bpbf_pkg::VEC_W-1:0] vm_in;

	logic signed [63:0]           bb_s14 [3];
	logic [bpbf_pkg::D_W-1:0]     d_s15;
	logic signed [63:0]           pa_s15 [3], pb_s15 [3];
	logic signed [48:0]           c_s16 [3];
	logic [bpbf_pkg::VEC_W-1:0]   vp_s17;
	logic signed [63:0]           qa_s18 [3], qb_s18 [3];
	logic signed [48:0]           c2_s [19:24][3];
	logic signed [67:0]           m_s25 [3];
	logic [bpbf_pkg::VEC_W-1:0]   res_s26;
	logic [bpbf_pkg::FAC_W-1:0]   fac;

	always_comb begin
		en[LAST] = !valid_s[LAST] || out_ready;
		for (int n = LAST - 1; n >= FIRST; n--) en[n] = !valid_s[n] || en[n+1];
	end

	assign in_ready = en[FIRST];
	assign out_valid = valid_s[LAST];
	assign out_vel = res_s26;
	assign out_oog = car_s[LAST].oog;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			if (en[FIRST]) valid_s[FIRST] <= in_valid;
			for (int n = FIRST + 1; n <= LAST; n++) begin
				if (en[n]) valid_s[n] <= valid_s[n-1];
			end
		end
	end

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			vm_in[j*bpbf_pkg::Q_W +: bpbf_pkg::Q_W] = bpbf_pkg::sat_q(
				64'(bpbf_pkg::comp(in_fld.vel, j)) + 64'(bpbf_pkg::comp(in_fld.e, j)));
		end
	end

	// 1/(1+|b|^2) scaled by two, ready with the delayed cross product
	bpbf_recip u_recip (
		.clk  (clk),
		.en   (en[24:16]),
		.d_in (d_s15),
		.fac  (fac)
	);

	always_ff @(posedge clk) begin
		if (en[FIRST]) begin
			car_s[FIRST] <= '{oog: in_fld.oog, vel: in_fld.vel, vm: vm_in, e: in_fld.e,
				b: in_fld.b};
		end
		for (int n = FIRST + 1; n <= LAST; n++) begin
			if (en[n]) car_s[n] <= car_s[n-1];
		end
		for (int j = 0; j < 3; j++) begin
			if (en[14]) bb_s14[j] <= bpbf_pkg::comp(in_fld.b, j) * bpbf_pkg::comp(in_fld.b, j);
			if (en[15]) begin
				pa_s15[j] <= bpbf_pkg::comp(car_s[14].vm, (j + 1) % 3)
					* bpbf_pkg::comp(car_s[14].b, (j + 2) % 3);
				pb_s15[j] <= bpbf_pkg::comp(car_s[14].vm, (j + 2) % 3)
					* bpbf_pkg::comp(car_s[14].b, (j + 1) % 3);
			end
			if (en[16]) c_s16[j] <= 49'(pa_s15[j] >>> bpbf_pkg::FRAC_W)
				- 49'(pb_s15[j] >>> bpbf_pkg::FRAC_W);
			if (en[17]) vp_s17[j*bpbf_pkg::Q_W +: bpbf_pkg::Q_W] <= bpbf_pkg::sat_q(
				64'(bpbf_pkg::comp(car_s[16].vm, j)) + 64'(c_s16[j]));
			if (en[18]) begin
				qa_s18[j] <= bpbf_pkg::comp(vp_s17, (j + 1) % 3)
					* bpbf_pkg::comp(car_s[17].b, (j + 2) % 3);
				qb_s18[j] <= bpbf_pkg::comp(vp_s17, (j + 2) % 3)
					* bpbf_pkg::comp(car_s[17].b, (j + 1) % 3);
			end
			if (en[19]) c2_s[19][j] <= 49'(qa_s18[j] >>> bpbf_pkg::FRAC_W)
				- 49'(qb_s18[j] >>> bpbf_pkg::FRAC_W);
			for (int n = 20; n <= 24; n++) begin
				if (en[n]) c2_s[n][j] <= c2_s[n-1][j];
			end
			if (en[25]) m_s25[j] <= c2_s[24][j] * $signed({1'b0, fac});
			// out of grid hands the velocity back untouched
			if (en[26]) res_s26[j*bpbf_pkg::Q_W +: bpbf_pkg::Q_W] <= car_s[25].oog
				? bpbf_pkg::comp(car_s[25].vel, j)
				: bpbf_pkg::sat_q(64'(bpbf_pkg::comp(car_s[25].vm, j))
					+ 64'(m_s25[j] >>> bpbf_pkg::FRAC_W)
					+ 64'(bpbf_pkg::comp(car_s[25].e, j)));
		end
		if (en[15]) d_s15 <= bpbf_pkg::D_W'(65536) + bb_s14[0][63:16] + bb_s14[1][63:16]
			+ bb_s14[2][63:16];
	end

endmodule

>>> sv/boris_push_bilinear_field_top.sv
`timescale 1ns / 1ps
// top level of the bilinear-field boris particle pusher
//
//  channel   direction  handshake                  content
//  s_axis    in         s_axis_tvalid/tready       load or push item, func in tuser
//  m_axis    out        m_axis_tvalid/tready       pushed velocity, out_of_grid in tuser
//  cfg       in         cfg_valid/cfg_ready        register index and write data
//
// one item per cycle sustained while m_axis_tready stays high; a push result passes locate,
// the store read, interpolation and the kick, whose divider for the rotation factor has
// nine stages. loads and function code 3 give no result.
// reset clears all valid bits and returns the cfg registers to defaults; the field stores stay undefined until loaded.
// every stage holds while the one after it is full and stalled, so bubbles close up.
module boris_push_bilinear_field_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// cell_index, field_x, field_y, field_z, pos_x, pos_z, vel_x, vel_y, vel_z, zero pad
	input  logic [bpbf_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// func
	input  logic [1:0]                           s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// new_vel_x, new_vel_y, new_vel_z
	output logic [bpbf_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	// out_of_grid
	output logic                                 m_axis_tuser,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bpbf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bpbf_pkg::Q_W-1:0]             cfg_data
);

	bpbf_pkg::cfg_t cfg_q;

	logic           loc_valid, loc_ready;
	bpbf_pkg::loc_t loc;
	logic           rd_valid, rd_ready;
	bpbf_pkg::rd_t  rd;
	logic           fld_valid, fld_ready;
	bpbf_pkg::fld_t fld;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x <= '0;
			cfg_q.origin_z <= '0;
			cfg_q.inv_cell_x <= 31'd65536;
			cfg_q.inv_cell_z <= 31'd65536;
			cfg_q.half_em_dt <= '0;
		end else if (cfg_valid) begin
			case (bpbf_pkg::cfg_idx_t'(cfg_index))
				bpbf_pkg::CFG_ORIGIN_X: cfg_q.origin_x <= cfg_data;
				bpbf_pkg::CFG_ORIGIN_Z: cfg_q.origin_z <= cfg_data;
				bpbf_pkg::CFG_INV_CELL_X: cfg_q.inv_cell_x <= cfg_data[30:0];
				bpbf_pkg::CFG_INV_CELL_Z: cfg_q.inv_cell_z <= cfg_data[30:0];
				bpbf_pkg::CFG_HALF_EM_DT: cfg_q.half_em_dt <= cfg_data;
				default: ;
			endcase
		end
	end

	bpbf_locate u_locate (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.in_func       (s_axis_tuser),
		.in_cell_index (s_axis_tdata[11:0]),
		.in_fld        (s_axis_tdata[107:12]),
		.in_pos_x      (s_axis_tdata[139:108]),
		.in_pos_z      (s_axis_tdata[171:140]),
		.in_vel        (s_axis_tdata[267:172]),
		.out_valid     (loc_valid),
		.out_ready     (loc_ready),
		.out_loc       (loc)
	);

	bpbf_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (loc_valid),
		.in_ready  (loc_ready),
		.in_loc    (loc),
		.out_valid (rd_valid),
		.out_ready (rd_ready),
		.out_rd    (rd)
	);

	bpbf_interp u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (rd_valid),
		.in_ready  (rd_ready),
		.in_rd     (rd),
		.out_valid (fld_valid),
		.out_ready (fld_ready),
		.out_fld   (fld)
	);

	bpbf_kick u_kick (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fld_valid),
		.in_ready  (fld_ready),
		.in_fld    (fld),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_vel   (m_axis_tdata),
		.out_oog   (m_axis_tuser)
	);

endmodule
